### hw/rtl/jdc_pkg.sv
// Shared types, constants and the month-offset table for the Julian day converter.
// Depends on nothing; every file of the block imports it.
package jdc_pkg;

   // Operation codes carried in the request item.
   typedef enum logic {
      OP_DATE_TO_NUM = 1'b0,
      OP_NUM_TO_DATE = 1'b1
   } op_type;

   // Request item.
   typedef struct packed {
      op_type      operation;
      logic [13:0] date_year;
      logic [3:0]  date_month;
      logic [4:0]  date_day;
      logic [22:0] day_number;
      logic [16:0] seconds_of_day;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [22:0] number_out;
      logic [2:0]  weekday;
      logic [8:0]  year_day_index;
      logic [13:0] res_year;
      logic [3:0]  res_month;
      logic [4:0]  res_day;
      logic [4:0]  res_hour;
      logic [5:0]  res_minute;
      logic [5:0]  res_second;
      logic        out_of_range;
   } rsp_type;

   // Working fields of one item as it moves down the pipeline.
   typedef struct packed {
      op_type      op;
      logic        bad;
      logic [13:0] yr;
      logic [3:0]  mon;
      logic [4:0]  day;
      logic [22:0] dnum;
      logic [16:0] secs;
      logic [23:0] xa;
      logic [30:0] pa;
      logic [6:0]  alpha;
      logic [22:0] ph;
      logic [4:0]  hour;
      logic [11:0] remh;
      logic [18:0] pm;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [22:0] b;
      logic [29:0] xc;
      logic [44:0] pc;
      logic [13:0] c;
      logic [22:0] d;
      logic [8:0]  k;
      logic [27:0] pe;
      logic [3:0]  e;
      logic [8:0]  f;
      logic [4:0]  dd;
      logic [3:0]  mm;
      logic [13:0] yy;
      logic [13:0] yv;
      logic [21:0] py;
      logic [6:0]  acen;
      logic        leap;
      logic [22:0] eyear;
      logic [23:0] base;
      logic [22:0] num;
      logic [8:0]  yday;
      logic [43:0] pw;
   } pipe_type;

   // Supported span.
   localparam logic [13:0] YEAR_MIN      = 14'd1583;
   localparam logic [13:0] YEAR_MAX      = 14'd9999;
   localparam logic [3:0]  MONTH_MAX     = 4'd12;
   localparam logic [3:0]  MONTH_FEB     = 4'd2;
   localparam logic [22:0] DAY_NUM_FIRST = 23'd2299238;
   localparam logic [22:0] DAY_NUM_LAST  = 23'd5373483;
   localparam logic [16:0] SEC_MAX       = 17'd86399;

   // Offsets of the integer Meeus method.
   localparam logic [24:0] ALPHA_OFS = 25'd7468865;
   localparam logic [22:0] B_OFS     = 23'd1526;
   localparam logic [29:0] XC_OFS    = 30'd12210;
   localparam logic [13:0] YY_OFS_LO = 14'd4715;
   localparam logic [13:0] YY_OFS_HI = 14'd4716;
   localparam logic [13:0] Y_OFS     = 14'd4716;
   localparam logic [23:0] N_OFS     = 24'd1525;
   localparam logic [23:0] N0_OFS    = 24'd1096;
   localparam logic [8:0]  YD_OFS_JF = 9'd429;
   localparam logic [8:0]  YD_OFS_MD = 9'd64;

   // Constant divisors; each quotient is a floor reciprocal product plus one correction.
   localparam int unsigned DIV_A   = 146097;
   localparam int unsigned DIV_A_S = 24;
   localparam logic [6:0]  DIV_A_M = 7'((64'd1 << DIV_A_S) / 64'(DIV_A));

   localparam int unsigned DIV_H   = 3600;
   localparam int unsigned DIV_H_S = 17;
   localparam logic [5:0]  DIV_H_M = 6'((64'd1 << DIV_H_S) / 64'(DIV_H));

   localparam int unsigned DIV_MIN   = 60;
   localparam int unsigned DIV_MIN_S = 12;
   localparam logic [6:0]  DIV_MIN_M = 7'((64'd1 << DIV_MIN_S) / 64'(DIV_MIN));

   localparam int unsigned DIV_C   = 36525;
   localparam int unsigned DIV_C_S = 30;
   localparam logic [14:0] DIV_C_M = 15'((64'd1 << DIV_C_S) / 64'(DIV_C));

   localparam int unsigned DIV_E     = 306001;
   localparam int unsigned DIV_E_S   = 23;
   localparam int unsigned E_SCALE   = 10000;
   localparam logic [18:0] DIV_E_MK  =
      19'(64'(E_SCALE) * ((64'd1 << DIV_E_S) / 64'(DIV_E)));

   localparam int unsigned DIV_Y   = 100;
   localparam int unsigned DIV_Y_S = 14;
   localparam logic [7:0]  DIV_Y_M = 8'((64'd1 << DIV_Y_S) / 64'(DIV_Y));

   localparam int unsigned DIV_W   = 7;
   localparam int unsigned DIV_W_S = 23;
   localparam logic [20:0] DIV_W_M = 21'((64'd1 << DIV_W_S) / 64'(DIV_W));

   // floor(306001 * k / 10000): days from March 1 up to the month behind index k.
   function automatic logic [8:0] f_of_k(input logic [3:0] k);
      logic [8:0] f;
      case (k)
         4'd0:    f = 9'd0;
         4'd1:    f = 9'd30;
         4'd2:    f = 9'd61;
         4'd3:    f = 9'd91;
         4'd4:    f = 9'd122;
         4'd5:    f = 9'd153;
         4'd6:    f = 9'd183;
         4'd7:    f = 9'd214;
         4'd8:    f = 9'd244;
         4'd9:    f = 9'd275;
         4'd10:   f = 9'd306;
         4'd11:   f = 9'd336;
         4'd12:   f = 9'd367;
         4'd13:   f = 9'd397;
         4'd14:   f = 9'd428;
         4'd15:   f = 9'd459;
         default: f = 9'd0;
      endcase
      return f;
   endfunction

endpackage

### hw/rtl/julian_day_conversion_top.sv
// Top level of the Julian day converter: a 16-stage pipeline plus an output register.
// Depends on jdc_pkg for the item types, constants and the month-offset table.
//
//   Channel | Ports                               | Moves
//   --------+-------------------------------------+----------------------------------
//   request | req_valid, req_ready, req_payload   | one conversion item (req_type)
//   result  | rsp_valid, rsp_ready, rsp_payload   | one result item per request (rsp_type)
//
// One item enters per cycle unless every stage is full while the result waits.
// Latency is set by the chain of constant divisions, each a reciprocal multiply then a correction.
// Reset clears only the stage valid bits and the output valid bit.
// A stalled result holds only the stages that are full behind it; bubbles ahead still fill.
// A stage holds only when it and every later stage are full while the result waits.
module julian_day_conversion_top
   import jdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int NS = 16;

   pipe_type      st_ff [NS];
   pipe_type      st_in [NS];
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] vld_up;
   logic [NS:0]   adv;
   logic          out_stall;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_vld_ff;
   logic          rsp_vld_in;

   // Intermediate values of the correction steps.
   logic [6:0]  qa;
   logic [23:0] ra;
   logic [4:0]  qh;
   logic [16:0] rh;
   logic [5:0]  qm;
   logic [11:0] rm;
   logic [13:0] qc;
   logic [29:0] rc;
   logic [4:0]  qe;
   logic [22:0] re;
   logic [4:0]  eq;
   logic [3:0]  mm_t;
   logic [6:0]  qy;
   logic [13:0] ry;
   logic [6:0]  r100;
   logic [6:0]  acen_t;
   logic [23:0] n_full;
   logic [23:0] n0_full;
   logic [8:0]  yd_ofs;
   logic [20:0] qw;
   logic [3:0]  rw;
   logic [2:0]  wd;

   // Stall control: a stage holds only when it and every later stage are full
   // and the output register is blocked.
   assign out_stall = rsp_vld_ff && !rsp_ready;
   assign adv[NS]   = !out_stall;

   for (genvar g = 0; g < NS; g++) begin : g_adv
      assign adv[g] = !(out_stall && (&vld_ff[NS-1:g]));
   end

   assign req_ready = adv[0];
   assign vld_up    = {vld_ff[NS-2:0], req_valid};
   assign vld_in    = (vld_up & adv[NS-1:0]) | (vld_ff & ~adv[NS-1:0]);
   assign rsp_vld_in = adv[NS] ? vld_ff[NS-1] : rsp_vld_ff;

   // Stage 0: capture the item, check its span and prepare the first dividend.
   always_comb begin
      st_in[0]      = '0;
      st_in[0].op   = req_payload.operation;
      st_in[0].mon  = req_payload.date_month;
      st_in[0].day  = req_payload.date_day;
      st_in[0].dnum = req_payload.day_number;
      st_in[0].secs = (req_payload.seconds_of_day > SEC_MAX) ? SEC_MAX
                                                              : req_payload.seconds_of_day;
      if (req_payload.operation == OP_DATE_TO_NUM) begin
         st_in[0].bad = (req_payload.date_year < YEAR_MIN) ||
                        (req_payload.date_year > YEAR_MAX) ||
                        (req_payload.date_month == 4'd0) ||
                        (req_payload.date_month > MONTH_MAX) ||
                        (req_payload.date_day == 5'd0);
      end else begin
         st_in[0].bad = (req_payload.day_number < DAY_NUM_FIRST) ||
                        (req_payload.day_number > DAY_NUM_LAST);
      end
      // January and February count as months 13 and 14 of the year before.
      if (req_payload.date_month <= MONTH_FEB) begin
         st_in[0].yr = req_payload.date_year - 14'd1;
         st_in[0].e  = req_payload.date_month + 4'd13;
      end else begin
         st_in[0].yr = req_payload.date_year;
         st_in[0].e  = req_payload.date_month + 4'd1;
      end
      // 4 * (day_number + 1) - 7468865 lands in 24 bits for every day number in span.
      st_in[0].xa = 24'({req_payload.day_number, 2'b00} + 25'd4 - ALPHA_OFS);
   end

   // Stage 1: reciprocal products for the century term and the hour.
   always_comb begin
      st_in[1]    = st_ff[0];
      st_in[1].pa = 31'(st_ff[0].xa) * 31'(DIV_A_M);
      st_in[1].ph = 23'(st_ff[0].secs) * 23'(DIV_H_M);
   end

   // Stage 2: correct the century quotient and the hour.
   always_comb begin
      st_in[2] = st_ff[1];
      qa = st_ff[1].pa[30:24];
      ra = st_ff[1].xa - 24'(25'(qa) * 25'(DIV_A));
      st_in[2].alpha = (ra >= 24'(DIV_A)) ? qa + 7'd1 : qa;
      qh = st_ff[1].ph[21:17];
      rh = st_ff[1].secs - 17'(qh * 17'(DIV_H));
      if (rh >= 17'(DIV_H)) begin
         st_in[2].hour = qh + 5'd1;
         st_in[2].remh = 12'(rh - 17'(DIV_H));
      end else begin
         st_in[2].hour = qh;
         st_in[2].remh = 12'(rh);
      end
   end

   // Stage 3: Gregorian shift of the day number, and the minute product.
   always_comb begin
      st_in[3]   = st_ff[2];
      st_in[3].b = st_ff[2].dnum + B_OFS + 23'(st_ff[2].alpha) - 23'(st_ff[2].alpha >> 2);
      st_in[3].pm = 19'(st_ff[2].remh) * 19'(DIV_MIN_M);
   end

   // Stage 4: dividend for the year count, and minute and second.
   always_comb begin
      st_in[4]    = st_ff[3];
      st_in[4].xc = 30'(st_ff[3].b) * 30'd100 - XC_OFS;
      qm = st_ff[3].pm[17:12];
      rm = st_ff[3].remh - 12'(qm * 12'(DIV_MIN));
      if (rm >= 12'(DIV_MIN)) begin
         st_in[4].minute = qm + 6'd1;
         st_in[4].second = 6'(rm - 12'(DIV_MIN));
      end else begin
         st_in[4].minute = qm;
         st_in[4].second = 6'(rm);
      end
   end

   // Stage 5: reciprocal product for the year count.
   always_comb begin
      st_in[5]    = st_ff[4];
      st_in[5].pc = 45'(st_ff[4].xc) * 45'(DIV_C_M);
   end

   // Stage 6: correct the year count.
   always_comb begin
      st_in[6] = st_ff[5];
      qc = st_ff[5].pc[43:30];
      rc = st_ff[5].xc - 30'(30'(qc) * 30'(DIV_C));
      st_in[6].c = (rc >= 30'(DIV_C)) ? qc + 14'd1 : qc;
   end

   // Stage 7: days in whole years, and the day within the March-based year.
   always_comb begin
      st_in[7]   = st_ff[6];
      st_in[7].d = 23'((25'(st_ff[6].c) * 25'd1461) >> 2);
      st_in[7].k = 9'(st_ff[6].b - st_in[7].d);
   end

   // Stage 8: reciprocal product for the month index.
   always_comb begin
      st_in[8]    = st_ff[7];
      st_in[8].pe = 28'(st_ff[7].k) * 28'(DIV_E_MK);
   end

   // Stage 9: correct the month index; date items keep the index from their month.
   always_comb begin
      st_in[9] = st_ff[8];
      qe = st_ff[8].pe[27:23];
      re = 23'(st_ff[8].k) * 23'(E_SCALE) - 23'(23'(qe) * 23'(DIV_E));
      eq = (re >= 23'(DIV_E)) ? qe + 5'd1 : qe;
      if (st_ff[8].op == OP_NUM_TO_DATE) begin
         st_in[9].e = eq[3:0];
      end
   end

   // Stage 10: month offset, then day, month and year of a day number.
   always_comb begin
      st_in[10]   = st_ff[9];
      st_in[10].f = f_of_k(st_ff[9].e);
      st_in[10].dd = 5'(st_ff[9].k - st_in[10].f);
      mm_t = st_ff[9].e - 4'd1;
      if (mm_t > MONTH_MAX) begin
         mm_t = mm_t - MONTH_MAX;
      end
      st_in[10].mm = mm_t;
      st_in[10].yy = (mm_t <= MONTH_FEB) ? st_ff[9].c - YY_OFS_LO : st_ff[9].c - YY_OFS_HI;
   end

   // Stage 11: pick the year whose base is needed and form its century product.
   always_comb begin
      st_in[11]    = st_ff[10];
      st_in[11].yv = (st_ff[10].op == OP_NUM_TO_DATE) ? st_ff[10].yy - 14'd1 : st_ff[10].yr;
      st_in[11].py = 22'(st_in[11].yv) * 22'(DIV_Y_M);
   end

   // Stage 12: century and leap year, and the days of the whole Julian years.
   always_comb begin
      st_in[12] = st_ff[11];
      qy = st_ff[11].py[20:14];
      ry = st_ff[11].yv - 14'(14'(qy) * 14'(DIV_Y));
      if (ry >= 14'(DIV_Y)) begin
         acen_t = qy + 7'd1;
         r100   = 7'(ry - 14'(DIV_Y));
      end else begin
         acen_t = qy;
         r100   = 7'(ry);
      end
      st_in[12].acen  = acen_t;
      st_in[12].leap  = (st_ff[11].yv[1:0] == 2'd0) &&
                        ((r100 != 7'd0) || (acen_t[1:0] == 2'd0));
      st_in[12].eyear = 23'((25'(st_ff[11].yv + Y_OFS) * 25'd1461) >> 2);
   end

   // Stage 13: year base with the Gregorian century correction.
   always_comb begin
      st_in[13] = st_ff[12];
      st_in[13].base = 24'(st_ff[12].eyear) + 24'd2 - 24'(st_ff[12].acen) +
                       24'(st_ff[12].acen >> 2);
   end

   // Stage 14: day number and day of year.
   always_comb begin
      st_in[14] = st_ff[13];
      n_full  = st_ff[13].base + 24'(st_ff[13].day) + 24'(st_ff[13].f) - N_OFS;
      n0_full = st_ff[13].base - N0_OFS;
      yd_ofs  = (st_ff[13].mon <= MONTH_FEB) ? YD_OFS_JF : YD_OFS_MD;
      if (st_ff[13].op == OP_DATE_TO_NUM) begin
         st_in[14].num  = 23'(n_full);
         st_in[14].yday = 9'(st_ff[13].day) + st_ff[13].f - yd_ofs +
                          9'((st_ff[13].mon > MONTH_FEB) && st_ff[13].leap);
      end else begin
         st_in[14].num  = st_ff[13].dnum;
         st_in[14].yday = 9'(st_ff[13].dnum - 23'(n0_full));
      end
   end

   // Stage 15: reciprocal product for the weekday.
   always_comb begin
      st_in[15]    = st_ff[14];
      st_in[15].pw = 44'(st_ff[14].num) * 44'(DIV_W_M);
   end

   // Output stage: weekday, then the fields each operation reports.
   always_comb begin
      qw = st_ff[15].pw[43:23];
      rw = 4'(st_ff[15].num - 23'(24'(qw) * 24'(DIV_W)));
      if (rw >= 4'(DIV_W)) begin
         rw = rw - 4'(DIV_W);
      end
      wd = (rw == 4'd6) ? 3'd0 : 3'(rw + 4'd1);
      rsp_in = '0;
      rsp_in.out_of_range = st_ff[15].bad;
      if (st_ff[15].op == OP_DATE_TO_NUM) begin
         if (!st_ff[15].bad) begin
            rsp_in.number_out     = st_ff[15].num;
            rsp_in.weekday        = wd;
            rsp_in.year_day_index = st_ff[15].yday;
         end
      end else begin
         rsp_in.weekday    = wd;
         rsp_in.res_hour   = st_ff[15].hour;
         rsp_in.res_minute = st_ff[15].minute;
         rsp_in.res_second = st_ff[15].second;
         if (!st_ff[15].bad) begin
            rsp_in.res_year       = st_ff[15].yy;
            rsp_in.res_month      = st_ff[15].mm;
            rsp_in.res_day        = st_ff[15].dd;
            rsp_in.year_day_index = st_ff[15].yday;
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Stage payloads and the output register.
   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (adv[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
      if (adv[NS]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // A full first stage that cannot move keeps its item.
   a_stage0_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !adv[0] |=> vld_ff[0] && $stable(st_ff[0]))
      else $error("stage 0 item lost or changed during a stall");

   // The last stage keeps its item while the result register is blocked.
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-1] && out_stall |=> vld_ff[NS-1])
      else $error("last stage item dropped behind a blocked result");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.weekday <= 3'd6)
      else $error("weekday outside Monday to Sunday");

   a_yday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.year_day_index <= 9'd365)
      else $error("day of year beyond 365");

   // A decoded date has a real month and a nonzero day.
   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.out_of_range && rsp_payload.res_month != 4'd0
      |-> rsp_payload.res_month <= MONTH_MAX && rsp_payload.res_day != 5'd0)
      else $error("decoded date has a bad month or day");

endmodule
